@@ rtl/sorted_key_value_table_assert.svh @@
// Assertion macros for the sorted key-value table.
// Included by the top level; depends on nothing else.
`ifndef SORTED_KEY_VALUE_TABLE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define SKVT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted key-value table: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define SKVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted key-value table: next-cycle check failed");

`endif

@@ rtl/skvt_pkg.sv @@
// Shared constants and types of the sorted key-value table.
// Used by skvt_cell and sorted_key_value_table; depends on nothing.
package skvt_pkg;

    localparam int Capacity = 16;
    localparam int KeyW     = 32;
    localparam int ValW     = 32;
    localparam int CntW     = $clog2(Capacity + 1);

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_INSERT = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic                   valid;
        logic signed [KeyW-1:0] key;
        logic signed [ValW-1:0] value;
    } entry_t;

    typedef struct packed {
        cell_op_t               op;
        logic signed [KeyW-1:0] key;
        logic signed [ValW-1:0] value;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DUMP   = 1'b1;

endpackage

@@ rtl/sorted_key_value_table.sv @@
// Top level of the sorted key-value table: a row of skvt_cell slots and the control.
// Depends on skvt_pkg, skvt_cell and sorted_key_value_table_assert.svh.
//
//   Channel   Direction  Carries
//   s_*       in         tuser: action; tdata: key, data_value
//   m_*       out        tdata: out_value; tlast: last; tuser: empty_res, dropped
//
// On an insert or update all slots compare and shift together.
// A dump holds off input and streams one value per cycle while m_tready does not stall
// the output; an empty dump or a dropped insert gives one transaction.
// Reset clears all slots to empty; stalls on m_tready hold the output register.
module sorted_key_value_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] data_value
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] out_value
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [0] empty_res, [1] dropped
);

    localparam int Cap = skvt_pkg::Capacity;

    skvt_pkg::state_t                state_reg, state_next;
    logic [skvt_pkg::CntW-1:0]       count_reg, count_next;
    logic [skvt_pkg::CntW-1:0]       remain_reg, remain_next;
    logic                            out_valid_reg, out_valid_next;
    logic [skvt_pkg::ValW-1:0]       out_value_reg, out_value_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_empty_reg, out_empty_next;
    logic                            out_drop_reg, out_drop_next;

    skvt_pkg::cell_cmd_t             cmd;
    skvt_pkg::entry_t                entries [Cap];
    logic [Cap-1:0]                  ge_vec;
    logic [Cap-1:0]                  match_vec;
    logic [Cap-1:0]                  valid_vec;
    logic                            out_free;
    logic                            in_acc;
    logic                            any_match;
    logic                            full;

    genvar gi;
    generate
        for (gi = 0; gi < Cap; gi++) begin : g_cell
            skvt_pkg::entry_t left_e;
            skvt_pkg::entry_t right_e;
            logic             left_g;
            if (gi == 0) begin : g_first
                assign left_e = '0;
                assign left_g = 1'b0;
            end else begin : g_mid
                assign left_e = entries[gi-1];
                assign left_g = ge_vec[gi-1];
            end
            if (gi == Cap - 1) begin : g_last
                assign right_e = '0;
            end else begin : g_inner
                assign right_e = entries[gi+1];
            end
            skvt_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .left_entry  (left_e),
                .left_ge     (left_g),
                .right_entry (right_e),
                .head_entry  (entries[0]),
                .entry       (entries[gi]),
                .ge          (ge_vec[gi]),
                .match       (match_vec[gi])
            );
            assign valid_vec[gi] = entries[gi].valid;
        end
    endgenerate

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == skvt_pkg::ST_IDLE) && out_free;
    assign in_acc    = s_tvalid && s_tready;
    assign any_match = |match_vec;
    assign full      = (count_reg == skvt_pkg::CntW'(Cap));

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_drop_next  = out_drop_reg;
        cmd.op         = skvt_pkg::OP_NONE;
        cmd.key        = s_tdata[31:0];
        cmd.value      = s_tdata[63:32];

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            skvt_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser[0] == skvt_pkg::ACT_DUMP) begin
                        if (count_reg == '0) begin
                            out_valid_next = 1'b1;
                            out_value_next = '0;
                            out_last_next  = 1'b1;
                            out_empty_next = 1'b1;
                            out_drop_next  = 1'b0;
                        end else begin
                            state_next  = skvt_pkg::ST_DUMP;
                            remain_next = count_reg;
                        end
                    end else if (any_match) begin
                        cmd.op = skvt_pkg::OP_UPDATE;
                    end else if (full) begin
                        out_valid_next = 1'b1;
                        out_value_next = '0;
                        out_last_next  = 1'b1;
                        out_empty_next = 1'b0;
                        out_drop_next  = 1'b1;
                    end else begin
                        cmd.op     = skvt_pkg::OP_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            skvt_pkg::ST_DUMP: begin
                if (out_free) begin
                    cmd.op         = skvt_pkg::OP_ROTATE;
                    out_valid_next = 1'b1;
                    out_value_next = entries[0].value;
                    out_last_next  = (remain_reg == skvt_pkg::CntW'(1));
                    out_empty_next = 1'b0;
                    out_drop_next  = 1'b0;
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == skvt_pkg::CntW'(1)) begin
                        state_next = skvt_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = skvt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= skvt_pkg::ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_drop_reg  <= out_drop_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_drop_reg, out_empty_reg};

`include "sorted_key_value_table_assert.svh"

    `SKVT_ASSERT_NOW(a_count_matches_slots, aclk, aresetn, 1'b1,
        $countones(valid_vec) == int'(count_reg))
    `SKVT_ASSERT_NOW(a_dump_has_work, aclk, aresetn,
        state_reg == skvt_pkg::ST_DUMP, remain_reg != '0)
    `SKVT_ASSERT_NEXT(a_dump_starts, aclk, aresetn,
        in_acc && (s_tuser[0] == skvt_pkg::ACT_DUMP) && (count_reg != '0),
        state_reg == skvt_pkg::ST_DUMP)
    `SKVT_ASSERT_NEXT(a_drop_keeps_count, aclk, aresetn,
        in_acc && (s_tuser[0] == skvt_pkg::ACT_INSERT) && full && !any_match,
        $stable(count_reg) && out_drop_reg)

endmodule

@@ rtl/skvt_cell.sv @@
// One slot of the sorted table: holds a key-value pair and trades it with its neighbors.
// Depends on skvt_pkg.
module skvt_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  skvt_pkg::cell_cmd_t cmd,
    input  skvt_pkg::entry_t    left_entry,
    input  logic                left_ge,
    input  skvt_pkg::entry_t    right_entry,
    input  skvt_pkg::entry_t    head_entry,
    output skvt_pkg::entry_t    entry,
    output logic                ge,
    output logic                match
);

    skvt_pkg::entry_t entry_reg;
    skvt_pkg::entry_t entry_next;
    logic             greater;

    assign entry   = entry_reg;
    assign match   = entry_reg.valid && (entry_reg.key == cmd.key);
    assign greater = entry_reg.valid && (cmd.key < entry_reg.key);
    assign ge      = !entry_reg.valid || greater;

    always_comb begin
        entry_next = entry_reg;
        case (cmd.op)
            skvt_pkg::OP_UPDATE: begin
                if (match) begin
                    entry_next.value = cmd.value;
                end
            end
            skvt_pkg::OP_INSERT: begin
                if (ge && !left_ge) begin
                    entry_next = '{valid: 1'b1, key: cmd.key, value: cmd.value};
                end else if (ge) begin
                    entry_next = left_entry;
                end
            end
            skvt_pkg::OP_ROTATE: begin
                if (entry_reg.valid) begin
                    entry_next = right_entry.valid ? right_entry : head_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

@@ tb/skvt_checker.sv @@
// Checker for the sorted key-value table: watches both stream channels, keeps its own
// copy of the sorted table and compares every result transaction with the prediction.
// Depends on skvt_pkg for the capacity, the field widths and the action codes.
module skvt_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] data_value
    input  logic [0:0]  s_tuser,   // [0] action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] out_value
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,   // [0] empty_res, [1] dropped
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [skvt_pkg::ValW-1:0] value;
        logic                             last;
        logic                             empty;
        logic                             dropped;
    } table_result_t;

    logic signed [skvt_pkg::KeyW-1:0] held_keys [skvt_pkg::Capacity];
    logic signed [skvt_pkg::ValW-1:0] held_vals [skvt_pkg::Capacity];
    int                               held_count = 0;
    table_result_t                    awaited_results [$];
    int                               mismatches = 0;

    task automatic note_result(input logic signed [skvt_pkg::ValW-1:0] v, input logic l,
                               input logic e, input logic d);
        table_result_t r;
        r.value   = v;
        r.last    = l;
        r.empty   = e;
        r.dropped = d;
        awaited_results.push_back(r);
    endtask

    task automatic apply_to_table(input logic act,
                                  input logic signed [skvt_pkg::KeyW-1:0] k,
                                  input logic signed [skvt_pkg::ValW-1:0] v);
        int  pos;
        int  i;
        bit  hit;
        bit  found_pos;
        pos       = held_count;
        hit       = 1'b0;
        found_pos = 1'b0;
        if (act == skvt_pkg::ACT_DUMP) begin
            if (held_count == 0) begin
                note_result('0, 1'b1, 1'b1, 1'b0);
            end else begin
                for (i = 0; i < held_count; i++) begin
                    note_result(held_vals[i], (i == held_count - 1), 1'b0, 1'b0);
                end
            end
        end else begin
            for (i = 0; i < held_count; i++) begin
                if (!hit && !found_pos) begin
                    if (held_keys[i] == k) begin
                        held_vals[i] = v;
                        hit = 1'b1;
                    end else if (k < held_keys[i]) begin
                        pos = i;
                        found_pos = 1'b1;
                    end
                end
            end
            if (!hit) begin
                if (held_count >= skvt_pkg::Capacity) begin
                    note_result('0, 1'b1, 1'b0, 1'b1);
                end else begin
                    for (i = held_count; i > pos; i--) begin
                        held_keys[i] = held_keys[i-1];
                        held_vals[i] = held_vals[i-1];
                    end
                    held_keys[pos] = k;
                    held_vals[pos] = v;
                    held_count++;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        table_result_t exp_r;
        if (!aresetn) begin
            held_count = 0;
            awaited_results.delete();
        end else begin
            // Results are compared before the new transaction is predicted, so an early
            // result can never be matched against an expectation created in the same cycle.
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result: out_value %h last %b empty %b dropped %b",
                             $time, m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
                    mismatches++;
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (m_tdata !== exp_r.value) begin
                        $display("%0t: out_value expected %h actual %h",
                                 $time, exp_r.value, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== exp_r.last) begin
                        $display("%0t: last expected %b actual %b",
                                 $time, exp_r.last, m_tlast);
                        mismatches++;
                    end
                    if (m_tuser[0] !== exp_r.empty) begin
                        $display("%0t: empty_res expected %b actual %b",
                                 $time, exp_r.empty, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tuser[1] !== exp_r.dropped) begin
                        $display("%0t: dropped expected %b actual %b",
                                 $time, exp_r.dropped, m_tuser[1]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_to_table(s_tuser[0], s_tdata[31:0], s_tdata[63:32]);
            end
        end
        fail_count <= mismatches;
        pending    <= awaited_results.size();
    end

endmodule

@@ tb/testbench.sv @@
// Top of the sorted key-value table testbench: clock, reset, stimulus and verdict.
// Depends on skvt_pkg, the sorted_key_value_table RTL and the skvt_checker module.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomItems = 310;
    localparam int HoldStart   = 400;
    localparam int HoldLength  = 300;

    localparam int RX_OPEN  = 0;
    localparam int RX_LOOSE = 1;
    localparam int RX_TIGHT = 2;

    localparam logic signed [31:0] KeyMin = 32'sh8000_0000;
    localparam logic signed [31:0] KeyMax = 32'sh7FFF_FFFF;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;

    int                     burst_left = 0;
    logic signed [31:0]     sent_keys [$];

    sorted_key_value_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    skvt_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("testbench NOT OK");
        $finish;
    end

    task automatic offer_pair(input logic act, input logic signed [31:0] k,
                              input logic signed [31:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {v, k};
        if (act == skvt_pkg::ACT_INSERT) begin
            sent_keys.push_back(k);
        end
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    function automatic logic signed [31:0] fresh_key();
        int                 pick;
        logic signed [31:0] k;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 3))
                0:       k = KeyMin;
                1:       k = KeyMax;
                2:       k = '0;
                default: k = -32'sd1;
            endcase
        end else if (pick == 1 && sent_keys.size() != 0) begin
            k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
            k = ($urandom_range(0, 1) == 0) ? k + 32'sd1 : k - 32'sd1;
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    initial begin
        int                 n;
        int                 pick;
        logic signed [31:0] k;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer_pair(skvt_pkg::ACT_DUMP, $urandom, $urandom);
        offer_pair(skvt_pkg::ACT_INSERT, 32'sd0, KeyMax);
        offer_pair(skvt_pkg::ACT_INSERT, KeyMax, KeyMin);
        offer_pair(skvt_pkg::ACT_INSERT, KeyMin, -32'sd1);
        offer_pair(skvt_pkg::ACT_INSERT, -32'sd1, 32'sd0);
        offer_pair(skvt_pkg::ACT_INSERT, 32'sd1, 32'sd1);
        offer_pair(skvt_pkg::ACT_DUMP, $urandom, $urandom);
        offer_pair(skvt_pkg::ACT_INSERT, 32'sd0, 32'sh5555_5555);
        offer_pair(skvt_pkg::ACT_INSERT, KeyMin, 32'shAAAA_AAAA);
        offer_pair(skvt_pkg::ACT_INSERT, 32'sh0001_0000, 32'sd123);
        offer_pair(skvt_pkg::ACT_DUMP, $urandom, $urandom);

        for (n = 0; n < RandomItems; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                offer_pair(skvt_pkg::ACT_DUMP, $urandom, $urandom);
            end else if (pick < 40 || sent_keys.size() == 0) begin
                offer_pair(skvt_pkg::ACT_INSERT, fresh_key(), $urandom);
            end else begin
                k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
                offer_pair(skvt_pkg::ACT_INSERT, k, $urandom);
            end
        end

        // The table should be full by now: a new key is then refused, an update still goes through.
        offer_pair(skvt_pkg::ACT_INSERT, $urandom, $urandom);
        offer_pair(skvt_pkg::ACT_INSERT, sent_keys[0], $urandom);
        offer_pair(skvt_pkg::ACT_DUMP, $urandom, $urandom);
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        int rx_mode;
        int rx_left;
        int tick;
        rx_mode = RX_OPEN;
        rx_left = 0;
        tick    = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            tick++;
            if (tick >= HoldStart && tick < HoldStart + HoldLength) begin
                m_tready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(RX_OPEN, RX_TIGHT);
                    rx_left = $urandom_range(5, 60);
                end
                rx_left--;
                case (rx_mode)
                    RX_OPEN:  m_tready <= 1'b1;
                    RX_LOOSE: m_tready <= 1'($urandom_range(0, 1));
                    default:  m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
            @(posedge aclk);
        end
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/skvt_pkg.sv
rtl/skvt_cell.sv
rtl/sorted_key_value_table.sv
tb/skvt_checker.sv
tb/testbench.sv
